FILE: rtl/lrdc_pkg.sv
// ----------------------------------------------------------------------------
// lrdc_pkg
// Shared types, character codes and helpers for the reply deframer and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lrdc_pkg;

  // Line length bound; a line is cut once it holds MAX_LINE-2 bytes.
  localparam int MAX_LINE = 128;
  localparam int LEN_W    = $clog2(MAX_LINE);

  localparam logic [7:0]  CHR_CR    = 8'h0D;
  localparam logic [7:0]  CHR_LF    = 8'h0A;
  localparam logic [7:0]  CHR_SEMI  = 8'h3B;
  localparam logic [7:0]  CHK_MASK  = 8'h3F;
  localparam logic [7:0]  CHK_BASE  = 8'h30;
  localparam logic [15:0] HEAD_PP   = 16'h5050;
  localparam logic [15:0] HEAD_II   = 16'h4949;
  localparam logic [15:0] HEAD_VV   = 16'h5656;
  localparam logic [15:0] HEAD_99   = 16'h3939;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  // Configuration register map.
  localparam int          CFG_ADDR_W   = 3;
  localparam logic        REG_SCAN_EN  = 1'b0;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_FEW  = 3'd1,
    ST_BAD_SUM  = 3'd2,
    ST_SCAN     = 3'd3,
    ST_NO_ID    = 3'd4
  } pkt_status_t;

  // One byte handed to the line core for processing.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } step_t;

  typedef struct packed {
    logic [2:0]  packet_status;
    logic [31:0] transaction_id;
    logic [15:0] bad_line;
    logic [15:0] line_count;
    logic [15:0] reply_status;
  } result_t;

  // Returns {is_hex, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lrdc_in_if.sv
// ----------------------------------------------------------------------------
// lrdc_in_if
// Byte channel into the deframer: valid, ready and one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrdc_out_if.sv
// ----------------------------------------------------------------------------
// lrdc_out_if
// Packet summary channel out of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  packet_status;
  logic [31:0] transaction_id;
  logic [15:0] bad_line;
  logic [15:0] line_count;
  logic [15:0] reply_status;

  modport source (output valid, output packet_status, output transaction_id,
                  output bad_line, output line_count, output reply_status,
                  input ready);
  modport sink   (input valid, input packet_status, input transaction_id,
                  input bad_line, input line_count, input reply_status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lrdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrdc_cfg_regs
// APB-style configuration register file: holds the scan handler enable.
// ----------------------------------------------------------------------------
`default_nettype none

module lrdc_cfg_regs
  import lrdc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic                       scan_en
);

  logic scan_en_r;
  logic scan_en_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    scan_en_nxt = scan_en_r;
    if (wr_en && paddr[2] == REG_SCAN_EN) begin
      scan_en_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b0;
    end else begin
      scan_en_r <= scan_en_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_SCAN_EN) begin
      prdata = {31'd0, scan_en_r};
    end
  end

  assign scan_en = scan_en_r;

endmodule

`default_nettype wire

FILE: rtl/lrdc_line_core.sv
// ----------------------------------------------------------------------------
// lrdc_line_core
// Per-byte line splitter, echo parser and line check byte verifier.
// ----------------------------------------------------------------------------
`default_nettype none

module lrdc_line_core
  import lrdc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    scan_en,
  input  wire step_t   step,
  output logic         pkt_end,
  output logic         emit,
  output result_t      res
);

  logic [15:0]      line_index_r, line_index_nxt;
  logic [LEN_W-1:0] line_len_r, line_len_nxt;
  logic [7:0]       psum_r, psum_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       sec_last_r, sec_last_nxt;
  logic [15:0]      echo_head_r, echo_head_nxt;
  logic [15:0]      status_head_r, status_head_nxt;
  logic [31:0]      id_acc_r, id_acc_nxt;
  logic             id_seen_r, id_seen_nxt;
  logic             id_parsing_r, id_parsing_nxt;
  logic [15:0]      first_bad_r, first_bad_nxt;

  logic [7:0]       c;
  logic [LEN_W:0]   n;
  logic             ends;
  logic [4:0]       hex;
  logic             special;
  logic             add_sec;
  logic [7:0]       sum;
  logic [7:0]       chk;
  logic             line_ok;
  logic [15:0]      count;
  logic [15:0]      index_inc;
  logic             has_id;
  logic [15:0]      status_upd;
  logic [15:0]      echo_upd;
  logic [31:0]      acc_upd;
  logic             seen_upd;
  logic             parsing_upd;
  pkt_status_t      status;

  assign c       = step.rx_byte;
  assign n       = {1'b0, line_len_r} + 1'b1;
  assign ends    = (c == CHR_CR) || (c == CHR_LF) || (n >= (LEN_W+1)'(MAX_LINE - 1));
  assign pkt_end = ends && (line_len_r == '0) && (c == CHR_LF);
  assign hex     = hex_nibble(c);

  // Echo head, reply status head and transaction id follow every byte of
  // their line, the terminating byte included.
  always_comb begin
    echo_upd    = echo_head_r;
    status_upd  = status_head_r;
    acc_upd     = id_acc_r;
    seen_upd    = id_seen_r;
    parsing_upd = id_parsing_r;
    if (line_index_r == 16'd0) begin
      if (line_len_r == LEN_W'(0)) begin
        echo_upd = {c, 8'h00};
      end else if (line_len_r == LEN_W'(1)) begin
        echo_upd = {echo_head_r[15:8], c};
      end
      if (id_parsing_r) begin
        if (hex[4]) begin
          acc_upd = {id_acc_r[27:0], hex[3:0]};
        end else begin
          parsing_upd = 1'b0;
        end
      end else if (!id_seen_r && c == CHR_SEMI) begin
        seen_upd    = 1'b1;
        parsing_upd = 1'b1;
      end
    end else if (line_index_r == 16'd1) begin
      if (line_len_r == LEN_W'(0)) begin
        status_upd = {c, 8'h00};
      end else if (line_len_r == LEN_W'(1)) begin
        status_upd = {status_head_r[15:8], c};
      end
    end
  end

  // The check byte is the byte before the terminator; a semicolon right before
  // it is left out of the sum for the PP, II and VV commands.
  assign special = (echo_head_r == HEAD_PP) || (echo_head_r == HEAD_II) ||
                   (echo_head_r == HEAD_VV);
  assign add_sec = (line_len_r >= LEN_W'(2)) && !(special && sec_last_r == CHR_SEMI);
  assign sum     = psum_r + (add_sec ? sec_last_r : 8'h00);
  assign chk     = (sum & CHK_MASK) + CHK_BASE;
  assign line_ok = (line_len_r != LEN_W'(0)) && (chk == last_r);

  assign index_inc = (line_index_r == CNT_MAX) ? CNT_MAX : line_index_r + 16'd1;
  assign count     = index_inc;
  assign has_id    = seen_upd;

  always_comb begin
    priority if (line_index_r == 16'd0) begin
      status = ST_TOO_FEW;
    end else if (first_bad_r != 16'd0) begin
      status = ST_BAD_SUM;
    end else if (scan_en && status_upd == HEAD_99) begin
      status = ST_SCAN;
    end else if (!has_id) begin
      status = ST_NO_ID;
    end else begin
      status = ST_OK;
    end
  end

  assign emit = step.valid && pkt_end;

  always_comb begin
    res.packet_status  = status;
    res.transaction_id = has_id ? acc_upd : 32'd0;
    res.bad_line       = (status == ST_BAD_SUM) ? first_bad_r : 16'd0;
    res.line_count     = count;
    res.reply_status   = status_upd;
  end

  always_comb begin
    line_index_nxt  = line_index_r;
    line_len_nxt    = line_len_r;
    psum_nxt        = psum_r;
    last_nxt        = last_r;
    sec_last_nxt    = sec_last_r;
    echo_head_nxt   = echo_head_r;
    status_head_nxt = status_head_r;
    id_acc_nxt      = id_acc_r;
    id_seen_nxt     = id_seen_r;
    id_parsing_nxt  = id_parsing_r;
    first_bad_nxt   = first_bad_r;
    if (step.valid) begin
      if (!ends) begin
        echo_head_nxt   = echo_upd;
        status_head_nxt = status_upd;
        id_acc_nxt      = acc_upd;
        id_seen_nxt     = seen_upd;
        id_parsing_nxt  = parsing_upd;
        if (line_len_r >= LEN_W'(2)) begin
          psum_nxt = psum_r + sec_last_r;
        end
        sec_last_nxt = last_r;
        last_nxt     = c;
        line_len_nxt = n[LEN_W-1:0];
      end else if (pkt_end) begin
        line_index_nxt  = 16'd0;
        line_len_nxt    = '0;
        psum_nxt        = 8'h00;
        last_nxt        = 8'h00;
        sec_last_nxt    = 8'h00;
        echo_head_nxt   = 16'd0;
        status_head_nxt = 16'd0;
        id_acc_nxt      = 32'd0;
        id_seen_nxt     = 1'b0;
        id_parsing_nxt  = 1'b0;
        first_bad_nxt   = 16'd0;
      end else begin
        echo_head_nxt   = echo_upd;
        status_head_nxt = status_upd;
        id_acc_nxt      = acc_upd;
        id_seen_nxt     = seen_upd;
        id_parsing_nxt  = 1'b0;
        if (line_index_r != 16'd0 && !line_ok && first_bad_r == 16'd0) begin
          first_bad_nxt = line_index_r;
        end
        line_index_nxt = index_inc;
        line_len_nxt   = '0;
        psum_nxt       = 8'h00;
        last_nxt       = 8'h00;
        sec_last_nxt   = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_index_r  <= 16'd0;
      line_len_r    <= '0;
      psum_r        <= 8'h00;
      last_r        <= 8'h00;
      sec_last_r    <= 8'h00;
      echo_head_r   <= 16'd0;
      status_head_r <= 16'd0;
      id_acc_r      <= 32'd0;
      id_seen_r     <= 1'b0;
      id_parsing_r  <= 1'b0;
      first_bad_r   <= 16'd0;
    end else begin
      line_index_r  <= line_index_nxt;
      line_len_r    <= line_len_nxt;
      psum_r        <= psum_nxt;
      last_r        <= last_nxt;
      sec_last_r    <= sec_last_nxt;
      echo_head_r   <= echo_head_nxt;
      status_head_r <= status_head_nxt;
      id_acc_r      <= id_acc_nxt;
      id_seen_r     <= id_seen_nxt;
      id_parsing_r  <= id_parsing_nxt;
      first_bad_r   <= first_bad_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/laser_reply_deframer_checker.sv
// ----------------------------------------------------------------------------
// laser_reply_deframer_checker
// Splits received bytes into reply lines, verifies each line's check byte and
// emits one summary item per packet.
// A packet-ending byte is held in the input register and its summary then in the result register.
// Throughput: one byte per cycle, unless a packet-ending byte meets a summary not yet taken;
// then the input stalls, but other bytes still pass the line state while a summary waits.
// Reset: synchronous active-low rst_n clears all line state, the valid flags and
// the configuration register.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_reply_deframer_checker
  import lrdc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lrdc_in_if.sink                    in_ch,
  lrdc_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  logic       scan_en;
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r, in_byte_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r, res_nxt;
  result_t    res;
  logic       emit;
  logic       pkt_end;
  logic       advance;
  logic       in_take;
  step_t      step;

  lrdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .scan_en (scan_en)
  );

  // A byte moves into the line state unless its summary would overwrite one
  // that has not been taken yet.
  assign step.valid   = advance;
  assign step.rx_byte = in_byte_r;

  lrdc_line_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .scan_en (scan_en),
    .step    (step),
    .pkt_end (pkt_end),
    .emit    (emit),
    .res     (res)
  );

  // pkt_end does not depend on step.valid, so the stall decision forms no
  // combinational loop.
  assign advance     = in_valid_r && (!pkt_end || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_ch.rx_byte;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    res_r     <= res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.packet_status  = res_r.packet_status;
  assign out_ch.transaction_id = res_r.transaction_id;
  assign out_ch.bad_line       = res_r.bad_line;
  assign out_ch.line_count     = res_r.line_count;
  assign out_ch.reply_status   = res_r.reply_status;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit && out_valid_r |-> out_ch.ready)
    else $error("summary overwritten before it was taken");

  a_bad_line_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.packet_status == ST_BAD_SUM) == (res_r.bad_line != 16'd0)))
    else $error("bad line index does not match packet status");

  a_too_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.packet_status == ST_TOO_FEW) == (res_r.line_count < 16'd2)))
    else $error("line count does not match too-few-lines status");

endmodule

`default_nettype wire
